[rtl/fcs_pkg.sv]
// shared types and constants for the flash command sequencer
// no dependencies; imported by fcs_front, fcs_fifo, fcs_back, the top level and the testbench
`timescale 1ns / 1ps

package fcs_pkg;

  localparam int ADDR_BITS  = 20;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // word address mask, all ones once ADDR_BITS covers the address field
  localparam logic [19:0] ADDR_MASK =
    (ADDR_BITS >= 20) ? 20'hFFFFF : 20'((64'd1 << ADDR_BITS) - 64'd1);

  // input command codes
  localparam logic [2:0] CMD_PROG  = 3'd0;
  localparam logic [2:0] CMD_ERASE = 3'd1;
  localparam logic [2:0] CMD_CFI   = 3'd2;
  localparam logic [2:0] CMD_ID    = 3'd3;
  localparam logic [2:0] CMD_RDARR = 3'd4;
  localparam logic [2:0] CMD_RET   = 3'd5;

  // completion status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_VERIFY  = 2'd2;
  localparam logic [1:0] ST_REJECT  = 2'd3;

  // job kinds handed from front to back
  localparam logic [2:0] JOB_PROG  = 3'd0;
  localparam logic [2:0] JOB_ERASE = 3'd1;
  localparam logic [2:0] JOB_MODE  = 3'd2;
  localparam logic [2:0] JOB_READ  = 3'd3;
  localparam logic [2:0] JOB_DONE  = 3'd4;

  // flash command words
  localparam logic [15:0] ADDR_UNL0  = 16'h5555;
  localparam logic [15:0] ADDR_UNL1  = 16'h2AAA;
  localparam logic [15:0] DATA_UNL0  = 16'hAAAA;
  localparam logic [15:0] DATA_UNL1  = 16'h5555;
  localparam logic [15:0] CODE_CFI   = 16'h9898;
  localparam logic [15:0] CODE_ID    = 16'h9090;
  localparam logic [15:0] CODE_RDARR = 16'hF0F0;
  localparam logic [15:0] CODE_PROG  = 16'h00A0;
  localparam logic [15:0] CODE_ERASE = 16'h0080;
  localparam logic [15:0] CODE_SECT  = 16'h0030;
  localparam logic [15:0] ERASED_WORD = 16'hFFFF;
  localparam logic [15:0] POLL_LIMIT_RESET = 16'd50000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [19:0] addr;
    logic [15:0] data;    // program word, or mode code for mode jobs
    logic [1:0]  status;  // reported on the finishing word
    logic        unl;     // send unlock prefix
  } job_t;

  typedef struct packed {
    logic        bus_valid;
    logic        bus_write;
    logic [19:0] bus_addr;
    logic [15:0] bus_data;
    logic        done_res;
    logic [1:0]  status;
    logic        last;
  } res_t;

endpackage

[rtl/fcs_front.sv]
// front end: accepts input words, tracks the command phase, emits one job per word
// depends on fcs_pkg
`timescale 1ns / 1ps

module fcs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [2:0]        in_tuser,
  input  logic [39:0]       in_tdata,
  input  logic              unlock_en,
  input  logic [15:0]       poll_limit,
  input  logic              q_full,
  output logic              q_push,
  output fcs_pkg::job_t     q_job
);
  import fcs_pkg::*;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_POLL   = 2'd1;
  localparam logic [1:0] PH_VERIFY = 2'd2;

  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] poll_cnt_r, poll_cnt_nxt;
  logic [15:0] expect_r, expect_nxt;
  logic [19:0] target_r, target_nxt;
  logic        timed_out_r, timed_out_nxt;

  logic [2:0]  cmd;
  logic [19:0] addr;
  logic [15:0] data;
  logic [15:0] lim;
  logic [15:0] cnt_inc;
  logic        accept;

  assign cmd       = in_tuser;
  assign addr      = in_tdata[19:0] & ADDR_MASK;
  assign data      = in_tdata[35:20];
  assign lim       = (poll_limit == 16'd0) ? 16'd1 : poll_limit;
  assign cnt_inc   = poll_cnt_r + 16'd1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  assign q_push    = accept;

  always_comb begin
    phase_nxt     = phase_r;
    poll_cnt_nxt  = poll_cnt_r;
    expect_nxt    = expect_r;
    target_nxt    = target_r;
    timed_out_nxt = timed_out_r;
    q_job.kind    = JOB_DONE;
    q_job.addr    = 20'd0;
    q_job.data    = 16'd0;
    q_job.status  = ST_REJECT;
    q_job.unl     = unlock_en;

    if (cmd <= CMD_RDARR && phase_r == PH_IDLE) begin
      q_job.status = ST_OK;
      case (cmd)
        CMD_PROG, CMD_ERASE: begin
          q_job.kind    = (cmd == CMD_PROG) ? JOB_PROG : JOB_ERASE;
          q_job.addr    = addr;
          q_job.data    = data;
          expect_nxt    = (cmd == CMD_PROG) ? data : ERASED_WORD;
          target_nxt    = addr;
          poll_cnt_nxt  = 16'd0;
          timed_out_nxt = 1'b0;
          phase_nxt     = PH_POLL;
        end
        CMD_CFI: begin
          q_job.kind = JOB_MODE;
          q_job.data = CODE_CFI;
        end
        CMD_ID: begin
          q_job.kind = JOB_MODE;
          q_job.data = CODE_ID;
        end
        default: begin
          q_job.kind = JOB_MODE;
          q_job.data = CODE_RDARR;
        end
      endcase
    end else if (cmd == CMD_RET && phase_r == PH_POLL) begin
      q_job.kind   = JOB_READ;
      q_job.addr   = target_r;
      q_job.status = ST_OK;
      if (data == expect_r) begin
        phase_nxt = PH_VERIFY;
      end else begin
        poll_cnt_nxt = cnt_inc;
        if (cnt_inc >= lim) begin
          timed_out_nxt = 1'b1;
          phase_nxt     = PH_VERIFY;
        end
      end
    end else if (cmd == CMD_RET && phase_r == PH_VERIFY) begin
      phase_nxt = PH_IDLE;
      if (data == expect_r) begin
        q_job.status = ST_OK;
      end else begin
        q_job.kind   = JOB_MODE;
        q_job.data   = CODE_RDARR;
        q_job.status = timed_out_r ? ST_TIMEOUT : ST_VERIFY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      poll_cnt_r  <= 16'd0;
      expect_r    <= 16'd0;
      target_r    <= 20'd0;
      timed_out_r <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      poll_cnt_r  <= poll_cnt_nxt;
      expect_r    <= expect_nxt;
      target_r    <= target_nxt;
      timed_out_r <= timed_out_nxt;
    end
  end

endmodule

[rtl/fcs_fifo.sv]
// job queue between front and back, flop based
// depends on fcs_pkg
`timescale 1ns / 1ps

module fcs_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fcs_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output fcs_pkg::job_t head_job
);
  import fcs_pkg::*;

  job_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_PTR_W:0]   count_r, count_nxt;

  assign full     = (count_r == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

[rtl/fcs_back.sv]
// back end: walks each job's bus sequence into an output register, one result word per cycle
// while a job is queued and the output is not stalled; depends on fcs_pkg
`timescale 1ns / 1ps

module fcs_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  fcs_pkg::job_t q_job,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output fcs_pkg::res_t out_res
);
  import fcs_pkg::*;

  localparam logic [2:0] OP_UNL0  = 3'd0;
  localparam logic [2:0] OP_UNL1  = 3'd1;
  localparam logic [2:0] OP_CMD   = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_DONE  = 3'd5;

  logic [2:0] step_r, step_nxt;
  logic       valid_r, valid_nxt;
  res_t       res_r, res_nxt;

  logic [2:0] idx;       // position in the full sequence with unlock prefixes
  logic [2:0] last_idx;
  logic [2:0] op;
  logic       advance;
  logic       is_last;

  assign advance   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  // map step to full-sequence index, skipping unlock slots when disabled
  always_comb begin
    case (q_job.kind)
      JOB_PROG:  last_idx = 3'd4;
      JOB_ERASE: last_idx = 3'd6;
      JOB_MODE:  last_idx = 3'd2;
      default:   last_idx = 3'd0;
    endcase
    if (q_job.unl || q_job.kind == JOB_READ || q_job.kind == JOB_DONE) begin
      idx = step_r;
    end else begin
      case (q_job.kind)
        JOB_PROG:  idx = step_r + 3'd2;
        JOB_ERASE: idx = (step_r == 3'd0) ? 3'd2 : step_r + 3'd4;
        default:   idx = 3'd2;
      endcase
    end
    is_last = (idx == last_idx);

    if (q_job.kind == JOB_READ) begin
      op = OP_READ;
    end else if (q_job.kind == JOB_DONE) begin
      op = OP_DONE;
    end else begin
      case (idx)
        3'd0:    op = OP_UNL0;
        3'd1:    op = OP_UNL1;
        3'd2:    op = OP_CMD;
        3'd3:    op = (q_job.kind == JOB_PROG) ? OP_WRITE : OP_UNL0;
        3'd4:    op = (q_job.kind == JOB_PROG) ? OP_READ : OP_UNL1;
        3'd5:    op = OP_WRITE;
        default: op = OP_READ;
      endcase
    end
  end

  always_comb begin
    res_nxt.bus_valid = 1'b1;
    res_nxt.bus_write = 1'b1;
    res_nxt.bus_addr  = 20'd0;
    res_nxt.bus_data  = 16'd0;
    res_nxt.done_res  = 1'b0;
    res_nxt.status    = ST_OK;
    res_nxt.last      = is_last;
    case (op)
      OP_UNL0: begin
        res_nxt.bus_addr = 20'(ADDR_UNL0);
        res_nxt.bus_data = DATA_UNL0;
      end
      OP_UNL1: begin
        res_nxt.bus_addr = 20'(ADDR_UNL1);
        res_nxt.bus_data = DATA_UNL1;
      end
      OP_CMD: begin
        res_nxt.bus_addr = 20'(ADDR_UNL0);
        case (q_job.kind)
          JOB_PROG:  res_nxt.bus_data = CODE_PROG;
          JOB_ERASE: res_nxt.bus_data = CODE_ERASE;
          default: begin
            res_nxt.bus_data = q_job.data;
            res_nxt.done_res = 1'b1;
            res_nxt.status   = q_job.status;
          end
        endcase
      end
      OP_WRITE: begin
        res_nxt.bus_addr = q_job.addr;
        res_nxt.bus_data = (q_job.kind == JOB_PROG) ? q_job.data : CODE_SECT;
      end
      OP_READ: begin
        res_nxt.bus_write = 1'b0;
        res_nxt.bus_addr  = q_job.addr;
      end
      default: begin
        res_nxt.bus_valid = 1'b0;
        res_nxt.bus_write = 1'b0;
        res_nxt.done_res  = 1'b1;
        res_nxt.status    = q_job.status;
      end
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    step_nxt  = step_r;
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        if (is_last) begin
          q_pop    = 1'b1;
          step_nxt = 3'd0;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !q_empty) begin
      res_r <= res_nxt;
    end
  end

endmodule

[rtl/flash_command_sequencer.sv]
// top level of the parallel nor flash command sequencer: config registers and wiring
// depends on fcs_pkg, fcs_front, fcs_fifo, fcs_back
`timescale 1ns / 1ps
//
//   channel  direction  handshake                 payload
//   in_      slave      in_tvalid / in_tready     tuser command, tdata address + data
//   out_     master     out_tvalid / out_tready   tdata bus access + status, tlast last
//   cfg_     apb slave  psel / penable / pready   unlock_enable @0x0, poll_limit @0x4
//
// the front takes one input word per cycle while the job queue has room and
// updates the phase at once; the back emits one result word per cycle while the
// output is not stalled; a job is 1 to 7 words long (erase with unlock is longest)
// the 4-entry job queue absorbs bursts; in_tready drops only when it is full
// output stalls hold the result register and back up into the queue
// rst_n is synchronous; reset puts config at unlock on, poll limit 50000

module flash_command_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // [2:0] command
  input  logic [39:0] in_tdata,   // [19:0] address, [35:20] data, [39:36] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] bus_valid, [1] bus_write, [21:2] bus_addr, [37:22] bus_data,
  // [38] done_res, [40:39] status, [47:41] zero
  output logic [47:0] out_tdata,
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fcs_pkg::*;

  localparam logic REG_UNLOCK = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  logic        unlock_en_r;
  logic [15:0] poll_limit_r;
  logic        cfg_wr;

  logic        q_push, q_pop, q_full, q_empty;
  job_t        push_job, head_job;
  res_t        res;

  // config registers, written on the apb access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unlock_en_r  <= 1'b1;
      poll_limit_r <= POLL_LIMIT_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_UNLOCK: unlock_en_r  <= cfg_pwdata[0];
        REG_LIMIT:  poll_limit_r <= cfg_pwdata[15:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_UNLOCK: cfg_prdata = {31'd0, unlock_en_r};
      REG_LIMIT:  cfg_prdata = {16'd0, poll_limit_r};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  // classify input words and track the poll / verify phase
  fcs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .unlock_en  (unlock_en_r),
    .poll_limit (poll_limit_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  // job queue decoupling front and back
  fcs_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (head_job)
  );

  // expand jobs into bus access words
  fcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {7'd0, res.status, res.done_res, res.bus_data, res.bus_addr,
                      res.bus_write, res.bus_valid};
  assign out_tlast = res.last;

endmodule

[bench/flash_command_sequencer_tb.sv]
`timescale 1ns / 1ps
// testbench for flash_command_sequencer: directed and random commands, read returns and
// register writes, with every result word checked against an in-bench sequencer model
// depends on fcs_pkg and the rtl of the sequencer

module flash_command_sequencer_tb;
  import fcs_pkg::*;

  localparam logic [2:0] CMD_BAD6       = 3'd6;
  localparam logic [2:0] CMD_BAD7       = 3'd7;
  localparam logic [2:0] REG_UNLOCK     = 3'd0;
  localparam logic [2:0] REG_POLL_LIMIT = 3'd4;
  localparam int         LIMIT_CYCLES   = 1000000;

  typedef enum logic [1:0] {PH_IDLE, PH_POLL, PH_VERIFY} flash_phase_t;

  // model of the sequencer and the queue of result words it still owes
  class flash_cmd_checker_t;
    bit           unlock_on;
    bit [15:0]    poll_max;
    flash_phase_t phase;
    bit [15:0]    poll_count;
    bit [15:0]    expected_word;
    bit [19:0]    target_addr;
    bit           timed_out;
    bit           is_erase;
    res_t         bus_words_due[$];
    int           errors;

    function new();
      unlock_on     = 1'b1;
      poll_max      = POLL_LIMIT_RESET;
      phase         = PH_IDLE;
      poll_count    = '0;
      expected_word = '0;
      target_addr   = '0;
      timed_out     = 1'b0;
      is_erase      = 1'b0;
      errors        = 0;
    endfunction

    function void note_failure(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void due(bit v, bit w, bit [19:0] a, bit [15:0] d, bit dn, bit [1:0] st);
      res_t r;
      r.bus_valid = v;
      r.bus_write = w;
      r.bus_addr  = a;
      r.bus_data  = d;
      r.done_res  = dn;
      r.status    = st;
      r.last      = 1'b0;
      bus_words_due.push_back(r);
    endfunction

    function void unlock_prefix();
      if (unlock_on) begin
        due(1'b1, 1'b1, {4'h0, ADDR_UNL0}, DATA_UNL0, 1'b0, ST_OK);
        due(1'b1, 1'b1, {4'h0, ADDR_UNL1}, DATA_UNL1, 1'b0, ST_OK);
      end
    endfunction

    function void mode_write(bit [15:0] code, bit [1:0] st);
      unlock_prefix();
      due(1'b1, 1'b1, {4'h0, ADDR_UNL0}, code, 1'b1, st);
    endfunction

    function void accept_word(logic [2:0] cmd, logic [19:0] addr_in, logic [15:0] data);
      bit [19:0] addr;
      bit [15:0] lim;
      res_t      tail;
      addr = addr_in & ADDR_MASK;
      lim  = (poll_max == 16'd0) ? 16'd1 : poll_max;
      if (cmd <= CMD_RDARR && phase == PH_IDLE) begin
        case (cmd)
          CMD_PROG, CMD_ERASE: begin
            unlock_prefix();
            if (cmd == CMD_PROG) begin
              due(1'b1, 1'b1, {4'h0, ADDR_UNL0}, CODE_PROG, 1'b0, ST_OK);
              due(1'b1, 1'b1, addr, data, 1'b0, ST_OK);
              expected_word = data;
              is_erase      = 1'b0;
            end else begin
              due(1'b1, 1'b1, {4'h0, ADDR_UNL0}, CODE_ERASE, 1'b0, ST_OK);
              unlock_prefix();
              due(1'b1, 1'b1, addr, CODE_SECT, 1'b0, ST_OK);
              expected_word = ERASED_WORD;
              is_erase      = 1'b1;
            end
            // first status poll goes out with the command
            due(1'b1, 1'b0, addr, 16'h0, 1'b0, ST_OK);
            target_addr = addr;
            poll_count  = '0;
            timed_out   = 1'b0;
            phase       = PH_POLL;
          end
          CMD_CFI: mode_write(CODE_CFI, ST_OK);
          CMD_ID:  mode_write(CODE_ID, ST_OK);
          default: mode_write(CODE_RDARR, ST_OK);
        endcase
      end else if (cmd == CMD_RET && phase == PH_POLL) begin
        if (data == expected_word) begin
          phase = PH_VERIFY;
        end else begin
          poll_count = poll_count + 16'd1;
          if (poll_count >= lim) begin
            timed_out = 1'b1;
            phase     = PH_VERIFY;
          end
        end
        due(1'b1, 1'b0, target_addr, 16'h0, 1'b0, ST_OK);
      end else if (cmd == CMD_RET && phase == PH_VERIFY) begin
        if (data == expected_word) due(1'b0, 1'b0, 20'h0, 16'h0, 1'b1, ST_OK);
        else mode_write(CODE_RDARR, timed_out ? ST_TIMEOUT : ST_VERIFY);
        phase = PH_IDLE;
      end else begin
        // busy command, idle read return or unknown code
        due(1'b0, 1'b0, 20'h0, 16'h0, 1'b1, ST_REJECT);
      end
      tail      = bus_words_due.pop_back();
      tail.last = 1'b1;
      bus_words_due.push_back(tail);
    endfunction

    function void check_word(logic [47:0] td, logic tl);
      res_t e;
      if (bus_words_due.size() == 0) begin
        note_failure($sformatf("result word %h last %b with nothing pending", td, tl));
        return;
      end
      e = bus_words_due.pop_front();
      if (td[0] !== e.bus_valid)
        note_failure($sformatf("bus_valid exp %b got %b", e.bus_valid, td[0]));
      if (td[1] !== e.bus_write)
        note_failure($sformatf("bus_write exp %b got %b", e.bus_write, td[1]));
      if (td[21:2] !== e.bus_addr)
        note_failure($sformatf("bus_addr exp %h got %h", e.bus_addr, td[21:2]));
      if (td[37:22] !== e.bus_data)
        note_failure($sformatf("bus_data exp %h got %h", e.bus_data, td[37:22]));
      if (td[38] !== e.done_res)
        note_failure($sformatf("done_res exp %b got %b", e.done_res, td[38]));
      if (td[40:39] !== e.status)
        note_failure($sformatf("status exp %0d got %0d", e.status, td[40:39]));
      if (tl !== e.last)
        note_failure($sformatf("last exp %b got %b", e.last, tl));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [2:0]  in_tuser;   // [2:0] command
  logic [39:0] in_tdata;   // [19:0] address, [35:20] data, [39:36] zero
  logic        out_tvalid;
  logic        out_tready;
  // [0] bus_valid, [1] bus_write, [21:2] bus_addr, [37:22] bus_data,
  // [38] done_res, [40:39] status, [47:41] zero
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  flash_cmd_checker_t chk;
  bit                 in_quiet;
  int                 cycle_count;

  flash_command_sequencer uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [19:0] pick_addr();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 20'h00000;
    if (r == 1) return 20'hFFFFF;
    return 20'($urandom);
  endfunction

  function automatic logic [2:0] pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return CMD_PROG;
    if (r < 60) return CMD_ERASE;
    if (r < 73) return CMD_CFI;
    if (r < 86) return CMD_ID;
    return CMD_RDARR;
  endfunction

  // read data for a return: the awaited word, a near miss or anything
  function automatic logic [15:0] pick_return(logic [15:0] want, int match_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < match_pct) return want;
    if (r < match_pct + 10) return want ^ (16'h1 << $urandom_range(0, 15));
    return 16'($urandom);
  endfunction

  task automatic send_word(logic [2:0] cmd, logic [19:0] addr, logic [15:0] data);
    int gap;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'h0, data, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chk.accept_word(cmd, addr, data);
  endtask

  task automatic send_odd_code();
    send_word(($urandom_range(0, 1) == 1) ? CMD_BAD7 : CMD_BAD6, pick_addr(), 16'($urandom));
  endtask

  task automatic run_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) in_quiet = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      case (chk.phase)
        PH_IDLE: begin
          if (r < 80) send_word(pick_command(), pick_addr(), 16'($urandom));
          else if (r < 90) send_word(CMD_RET, pick_addr(), 16'($urandom));
          else send_odd_code();
        end
        PH_POLL: begin
          if (r < 75) send_word(CMD_RET, pick_addr(), pick_return(chk.expected_word, 50));
          else if (r < 88) send_word(pick_command(), pick_addr(), 16'($urandom));
          else send_odd_code();
        end
        default: begin
          if (r < 80) send_word(CMD_RET, pick_addr(), pick_return(chk.expected_word, 70));
          else if (r < 90) send_word(pick_command(), pick_addr(), 16'($urandom));
          else send_odd_code();
        end
      endcase
    end
  endtask

  // matching returns bring any open program or erase back to idle
  task automatic settle_flash();
    while (chk.phase != PH_IDLE) send_word(CMD_RET, pick_addr(), chk.expected_word);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (chk.bus_words_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic apb_access(bit wr, logic [2:0] addr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic read_check(logic [2:0] addr, logic [31:0] want);
    logic [31:0] v;
    apb_access(1'b0, addr, 32'h0, v);
    if (v !== want) chk.note_failure($sformatf("register %0d read exp %h got %h", addr, want, v));
  endtask

  task automatic set_config(bit unlock_on, bit [15:0] poll_max);
    logic [31:0] unused;
    apb_access(1'b1, REG_UNLOCK, {31'h0, unlock_on}, unused);
    chk.unlock_on = unlock_on;
    apb_access(1'b1, REG_POLL_LIMIT, {16'h0, poll_max}, unused);
    chk.poll_max = poll_max;
    read_check(REG_UNLOCK, {31'h0, unlock_on});
    read_check(REG_POLL_LIMIT, {16'h0, poll_max});
  endtask

  // result side: ready with random holes, sometimes long open stretches
  initial begin
    int gap;
    int hold;
    out_tready <= 1'b0;
    repeat (9) @(posedge clk);
    forever begin
      gap = pick_gap(1'b0);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      repeat (hold) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) chk.check_word(out_tdata, out_tlast);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    bit        unlock_list [6];
    bit [15:0] limit_list [6];
    unlock_list = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    limit_list  = '{16'd0, 16'd2, 16'd65535, 16'd3, 16'd1, 16'd4};
    chk         = new();
    in_quiet    = 1'b0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tuser    <= '0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values of both registers
    read_check(REG_UNLOCK, 32'h1);
    read_check(REG_POLL_LIMIT, {16'h0, POLL_LIMIT_RESET});

    // mode commands, rejects, program and erase with unlock on
    send_word(CMD_CFI, 20'h00000, 16'h0000);
    send_word(CMD_ID, 20'hFFFFF, 16'hFFFF);
    send_word(CMD_RDARR, 20'h12345, 16'h5A5A);
    send_word(CMD_RET, 20'h00000, 16'h0000);       // read return while idle
    send_word(CMD_BAD6, 20'hFFFFF, 16'hFFFF);
    send_word(CMD_BAD7, 20'h00000, 16'h0000);
    send_word(CMD_PROG, 20'hFFFFF, 16'hFFFF);
    send_word(CMD_ERASE, 20'h00001, 16'h1234);     // command while polling
    send_word(CMD_RET, 20'h00000, 16'h0000);       // poll miss
    send_word(CMD_RET, 20'h00000, 16'hFFFF);       // poll hit
    send_word(CMD_BAD6, 20'h00000, 16'h0000);      // unknown code while verifying
    send_word(CMD_RET, 20'h00000, 16'hFFFF);       // verify ok
    send_word(CMD_ERASE, 20'h00000, 16'h0000);
    send_word(CMD_RET, 20'h00000, 16'hFFFF);
    send_word(CMD_RET, 20'h00000, 16'h0000);       // verify mismatch
    send_word(CMD_PROG, 20'h00000, 16'h0000);
    send_word(CMD_RET, 20'h00000, 16'h0000);
    send_word(CMD_RET, 20'h00000, 16'h0000);
    wait_drained();

    // unlock off, poll limit one: timeouts on both program and erase
    set_config(1'b0, 16'd1);
    send_word(CMD_PROG, 20'h12345, 16'hA5A5);
    send_word(CMD_RET, 20'h00000, 16'h0000);       // first miss times out
    send_word(CMD_RET, 20'h00000, 16'h0000);       // verify miss reports timeout
    send_word(CMD_ERASE, 20'hABCDE, 16'h0000);
    send_word(CMD_RET, 20'h00000, 16'h0000);
    send_word(CMD_RET, 20'h00000, 16'hFFFF);       // timed out but verify passes
    wait_drained();

    foreach (unlock_list[k]) begin
      set_config(unlock_list[k], limit_list[k]);
      run_random(62);
      in_quiet = 1'b0;
      settle_flash();
      wait_drained();
    end

    if (chk.errors == 0 && chk.bus_words_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
